// File: hdl/baro_pkg.sv
// Shared types and constants for the barometer compensation block.
// Calibration word struct, register map and arithmetic constants.
// No dependencies.
package baro_pkg;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int PIPE_DEPTH = 9;

	localparam logic [REG_IDX_W-1:0] REG_PSENS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POFF   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TCS    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TCO    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TREF   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TSLOPE = 3'd5;

	localparam logic [CAL_W-1:0] CAL_BAD_ONES = 16'hFFFF;

	localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [19:0] TEMP_COLD = -20'sd1500;
	localparam logic signed [20:0] X_OFS     = 21'sd2000;
	localparam logic signed [20:0] Y_OFS     = 21'sd1500;
	localparam logic signed [41:0] DIV23_BIAS = 42'sd8388607;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sens_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temp_slope;
	} cal_t;

endpackage

// File: hdl/baro_if.sv
// Valid/ready channel interfaces for raw conversions and compensated results.
// Standalone; no package dependency.
interface baro_conv_if;
	logic        valid;
	logic        ready;
	logic [23:0] raw_pressure;
	logic [23:0] raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface baro_res_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] pressure_centi;

	modport source(output valid, output valid_res, output temperature_centi,
		output pressure_centi, input ready);
	modport sink(input valid, input valid_res, input temperature_centi,
		input pressure_centi, output ready);
endinterface

// File: hdl/baro_cal_regs.sv
// APB register file for the six calibration words.
// Depends on baro_pkg.
module baro_cal_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [baro_pkg::ADDR_W-1:0] paddr,
	input  logic [baro_pkg::DATA_W-1:0] pwdata,
	output logic [baro_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output baro_pkg::cal_t              cal
);
	import baro_pkg::*;

	cal_t                 cal_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PSENS:  cal_q.pressure_sensitivity  <= pwdata[CAL_W-1:0];
				REG_POFF:   cal_q.pressure_offset       <= pwdata[CAL_W-1:0];
				REG_TCS:    cal_q.sens_temp_coeff       <= pwdata[CAL_W-1:0];
				REG_TCO:    cal_q.offset_temp_coeff     <= pwdata[CAL_W-1:0];
				REG_TREF:   cal_q.reference_temperature <= pwdata[CAL_W-1:0];
				REG_TSLOPE: cal_q.temp_slope            <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PSENS:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.pressure_sensitivity};
			REG_POFF:   prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.pressure_offset};
			REG_TCS:    prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.sens_temp_coeff};
			REG_TCO:    prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.offset_temp_coeff};
			REG_TREF:   prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.reference_temperature};
			REG_TSLOPE: prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.temp_slope};
			default:    prdata = '0;
		endcase
	end

endmodule

// File: hdl/baro_comp_pipe.sv
// Nine-stage compensation datapath: dT, first order terms, second order
// correction, split pressure product, saturation. Depends on baro_pkg, baro_if.
module baro_comp_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  baro_pkg::cal_t cal,
	baro_conv_if.sink      conv,
	baro_res_if.source     res
);
	import baro_pkg::*;

	localparam int NSTG = PIPE_DEPTH;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [47:0] hi_lim;
		logic signed [47:0] lo_lim;
		hi_lim = 48'sd2147483647;
		lo_lim = -48'sd2147483648;
		if (v > hi_lim)
			return 32'sh7FFF_FFFF;
		if (v < lo_lim)
			return 32'sh8000_0000;
		return $signed(v[31:0]);
	endfunction

	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	// a stage loads when empty or when its content moves on
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || res.ready;
		for (int k = NSTG - 1; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= conv.valid;
			for (int k = 2; k <= NSTG; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign conv.ready = adv[1];

	// stage 1: dT and usability
	logic signed [24:0] dt_c;
	logic               ok_c;
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;
	logic               ok_s1;

	assign dt_c = $signed({1'b0, conv.raw_temperature})
		- $signed({1'b0, cal.reference_temperature, 8'h00});
	assign ok_c = (conv.raw_pressure != '0) && (conv.raw_temperature != '0)
		&& (cal.pressure_sensitivity != '0) && (cal.pressure_sensitivity != CAL_BAD_ONES)
		&& (cal.pressure_offset != '0) && (cal.pressure_offset != CAL_BAD_ONES);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dt_s1 <= dt_c;
			d1_s1 <= conv.raw_pressure;
			ok_s1 <= ok_c;
		end
	end

	// stage 2: products with dT
	logic signed [41:0] tc_s2;
	logic signed [41:0] oc_s2;
	logic signed [41:0] sc_s2;
	logic signed [49:0] dsq_s2;
	logic [23:0]        d1_s2;
	logic               ok_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			tc_s2  <= dt_s1 * $signed({1'b0, cal.temp_slope});
			oc_s2  <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
			sc_s2  <= dt_s1 * $signed({1'b0, cal.sens_temp_coeff});
			dsq_s2 <= dt_s1 * dt_s1;
			d1_s2  <= d1_s1;
			ok_s2  <= ok_s1;
		end
	end

	// stage 3: first order TEMP, OFF, SENS
	logic signed [41:0] tq_c;
	logic signed [41:0] tsh_c;
	logic signed [41:0] osh_c;
	logic signed [41:0] ssh_c;
	logic signed [19:0] temp_s3;
	logic signed [37:0] off_s3;
	logic signed [37:0] sens_s3;
	logic [17:0]        t2_s3;
	logic [23:0]        d1_s3;
	logic               ok_s3;

	// division by 2^23 rounds toward zero
	assign tq_c  = tc_s2 + (tc_s2[41] ? DIV23_BIAS : 42'sd0);
	assign tsh_c = tq_c >>> 23;
	assign osh_c = oc_s2 >>> 6;
	assign ssh_c = sc_s2 >>> 7;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			temp_s3 <= $signed(tsh_c[19:0]) + TEMP_REF;
			off_s3  <= $signed({5'b0, cal.pressure_offset, 17'b0}) + $signed(osh_c[37:0]);
			sens_s3 <= $signed({6'b0, cal.pressure_sensitivity, 16'b0})
				+ $signed(ssh_c[37:0]);
			t2_s3   <= dsq_s2[48:31];
			d1_s3   <= d1_s2;
			ok_s3   <= ok_s2;
		end
	end

	// stage 4: squares for the low temperature correction
	logic signed [20:0] x_c;
	logic signed [20:0] y_c;
	logic signed [41:0] xxf_c;
	logic signed [41:0] yyf_c;
	logic [35:0]        xx_s4;
	logic [35:0]        yy_s4;
	logic               lt2_s4;
	logic               lt15_s4;
	logic signed [19:0] temp_s4;
	logic signed [37:0] off_s4;
	logic signed [37:0] sens_s4;
	logic [17:0]        t2_s4;
	logic [23:0]        d1_s4;
	logic               ok_s4;

	assign x_c   = $signed({temp_s3[19], temp_s3}) - X_OFS;
	assign y_c   = $signed({temp_s3[19], temp_s3}) + Y_OFS;
	assign xxf_c = x_c * x_c;
	assign yyf_c = y_c * y_c;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			xx_s4   <= xxf_c[35:0];
			yy_s4   <= yyf_c[35:0];
			lt2_s4  <= temp_s3 < TEMP_REF;
			lt15_s4 <= temp_s3 < TEMP_COLD;
			temp_s4 <= temp_s3;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			t2_s4   <= t2_s3;
			d1_s4   <= d1_s3;
			ok_s4   <= ok_s3;
		end
	end

	// stage 5: OFF2, SENS2, T2 applied to TEMP
	logic [37:0]        x5_c;
	logic [38:0]        y7_c;
	logic [39:0]        y11_c;
	logic [39:0]        off2_c;
	logic [39:0]        sens2_c;
	logic [39:0]        off2_s5;
	logic [39:0]        sens2_s5;
	logic signed [20:0] temp_s5;
	logic signed [37:0] off_s5;
	logic signed [37:0] sens_s5;
	logic [23:0]        d1_s5;
	logic               ok_s5;

	assign x5_c  = {xx_s4, 2'b00} + {2'b00, xx_s4};
	assign y7_c  = {yy_s4, 3'b000} - {3'b000, yy_s4};
	assign y11_c = {1'b0, yy_s4, 3'b000} + {3'b000, yy_s4, 1'b0} + {4'b0000, yy_s4};

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (lt2_s4) begin
			off2_c  = {3'b000, x5_c[37:1]};
			sens2_c = {4'b0000, x5_c[37:2]};
			if (lt15_s4) begin
				off2_c  = off2_c + {1'b0, y7_c};
				sens2_c = sens2_c + {1'b0, y11_c[39:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			temp_s5  <= $signed({temp_s4[19], temp_s4})
				- (lt2_s4 ? $signed({3'b000, t2_s4}) : 21'sd0);
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			d1_s5    <= d1_s4;
			ok_s5    <= ok_s4;
		end
	end

	// stage 6: corrected OFF and SENS
	logic signed [41:0] off_s6;
	logic signed [41:0] sens_s6;
	logic signed [20:0] temp_s6;
	logic [23:0]        d1_s6;
	logic               ok_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			off_s6  <= $signed({{4{off_s5[37]}}, off_s5}) - $signed({2'b00, off2_s5});
			sens_s6 <= $signed({{4{sens_s5[37]}}, sens_s5}) - $signed({2'b00, sens2_s5});
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
			ok_s6   <= ok_s5;
		end
	end

	// stage 7: D1*SENS as two partial products on SENS halves
	logic [44:0]        plo_s7;
	logic signed [45:0] phi_s7;
	logic signed [41:0] off_s7;
	logic signed [20:0] temp_s7;
	logic               ok_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			plo_s7  <= d1_s6 * sens_s6[20:0];
			phi_s7  <= $signed({1'b0, d1_s6}) * $signed(sens_s6[41:21]);
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
			ok_s7   <= ok_s6;
		end
	end

	// stage 8: (D1*SENS)>>21 - OFF; low product is non-negative so floor splits
	logic signed [47:0] diff_s8;
	logic signed [20:0] temp_s8;
	logic               ok_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			diff_s8 <= $signed({{2{phi_s7[45]}}, phi_s7})
				+ $signed({24'b0, plo_s7[44:21]})
				- $signed({{6{off_s7[41]}}, off_s7});
			temp_s8 <= temp_s7;
			ok_s8   <= ok_s7;
		end
	end

	// stage 9: output register
	logic signed [47:0] psh_c;
	logic               ok_s9;
	logic signed [31:0] tcen_s9;
	logic signed [31:0] pcen_s9;

	assign psh_c = diff_s8 >>> 15;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			ok_s9   <= ok_s8;
			tcen_s9 <= ok_s8 ? sat32($signed({{27{temp_s8[20]}}, temp_s8})) : 32'sd0;
			pcen_s9 <= ok_s8 ? sat32(psh_c) : 32'sd0;
		end
	end

	assign res.valid             = vld_q[NSTG];
	assign res.valid_res         = ok_s9;
	assign res.temperature_centi = tcen_s9;
	assign res.pressure_centi    = pcen_s9;

endmodule

// File: hdl/baro_pressure_temp_compensation.sv
// Top level of the barometer pressure/temperature compensation block.
// Depends on baro_pkg, baro_if, baro_cal_regs, baro_comp_pipe.
//
// Accepts raw pressure/temperature conversion pairs, one per cycle while the
// result side keeps up, and returns the compensated temperature (0.01 degC)
// and pressure (0.01 mbar), one result per pair, in order, through the
// nine-stage datapath (multiplies by dT, second order squares, the split
// D1*SENS product and saturation). A stalled result holds the last stage and
// empty stages upstream still fill. Calibration words sit at byte addresses
// 0x00..0x14. The user writes them through APB only while no conversion is
// in flight; the block itself does not enforce it.
module baro_pressure_temp_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [baro_pkg::ADDR_W-1:0] paddr,
	input  logic [baro_pkg::DATA_W-1:0] pwdata,
	output logic [baro_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	baro_conv_if.sink                   conv,
	baro_res_if.source                  res
);
	import baro_pkg::*;

	cal_t cal;

	baro_cal_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	baro_comp_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.cal    (cal),
		.conv   (conv),
		.res    (res)
	);

endmodule

// File: hdl/baro_chk.sv
// Port-level checker for the compensation block, bound to the top level.
// Depends on baro_pkg.
module baro_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               conv_valid,
	input logic               conv_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_valid_res,
	input logic signed [31:0] res_temperature_centi,
	input logic signed [31:0] res_pressure_centi
);
	import baro_pkg::*;

	logic [3:0] cnt_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = conv_valid && conv_ready;
	assign acc_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc_in && !acc_out) begin
			cnt_q <= cnt_q + 4'd1;
		end else if (!acc_in && acc_out) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != 4'd0)
		else $error("result without a pending transfer");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(PIPE_DEPTH))
		else $error("more transfers in flight than pipeline stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 4'd0 |-> conv_ready)
		else $error("empty pipeline not ready");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_valid_res)
			&& $stable(res_temperature_centi) && $stable(res_pressure_centi))
		else $error("stalled result changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_valid_res |-> res_temperature_centi == 32'sd0
			&& res_pressure_centi == 32'sd0)
		else $error("unusable result carries nonzero fields");

endmodule

bind baro_pressure_temp_compensation baro_chk u_baro_chk (
	.clk                   (clk),
	.arst_n                (arst_n),
	.conv_valid            (conv.valid),
	.conv_ready            (conv.ready),
	.res_valid             (res.valid),
	.res_ready             (res.ready),
	.res_valid_res         (res.valid_res),
	.res_temperature_centi (res.temperature_centi),
	.res_pressure_centi    (res.pressure_centi)
);

// File: tb/tb_baro_pressure_temp_compensation.sv
// Testbench for baro_pressure_temp_compensation: directed table, then random conversion pairs.
// Results are predicted in-bench and checked in order; calibration is written over APB.
// Depends on baro_pkg, baro_if and the block's RTL.
module tb_baro_pressure_temp_compensation;
	timeunit 1ns;
	timeprecision 1ps;
	import baro_pkg::*;

	localparam int    CYCLE_LIMIT  = 400000;
	localparam int    RAND_PHASES  = 8;
	localparam int    PHASE_ITEMS  = 244;
	localparam int    DIR_ROWS     = 21;
	localparam int    CFG_RESET    = -1;
	localparam longint S32_MAX     = 64'sd2147483647;
	localparam longint S32_MIN     = -64'sd2147483648;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic               valid_res;
		logic signed [31:0] temperature_centi;
		logic signed [31:0] pressure_centi;
	} comp_res_t;

	localparam comp_res_t NO_READING = '0;

	typedef struct {
		int          cfg;
		logic [23:0] d1;
		logic [23:0] d2;
		bit          typed;
		comp_res_t   want;
	} conv_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	baro_conv_if conv_ch();
	baro_res_if  res_ch();

	baro_pressure_temp_compensation DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.conv    (conv_ch),
		.res     (res_ch)
	);

	cal_t cfg_tab[6] = '{
		'{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
		'{16'hFFFF,  16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
		'{16'd46372, 16'd0,     16'd29059, 16'd27842, 16'd31553, 16'd28165},
		'{16'd46372, 16'hFFFF,  16'd29059, 16'd27842, 16'd31553, 16'd28165},
		'{16'hFFFE,  16'hFFFE,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
		'{16'd1,     16'd1,     16'd0,     16'd0,     16'd0,     16'd0}
	};

	conv_row_t dir_tab[DIR_ROWS] = '{
		'{CFG_RESET, 24'd1,        24'd1,        1'b1, NO_READING},
		'{CFG_RESET, 24'hFFFFFF,   24'hFFFFFF,   1'b1, NO_READING},
		'{0,         24'd6465444,  24'd8077636,  1'b0, NO_READING},
		'{0,         24'd0,        24'd8077636,  1'b1, NO_READING},
		'{0,         24'd6465444,  24'd0,        1'b1, NO_READING},
		'{0,         24'd0,        24'd0,        1'b1, NO_READING},
		'{0,         24'd1,        24'd1,        1'b0, NO_READING},
		'{0,         24'hFFFFFF,   24'hFFFFFF,   1'b0, NO_READING},
		'{0,         24'hFFFFFF,   24'd1,        1'b0, NO_READING},
		'{0,         24'd1,        24'hFFFFFF,   1'b0, NO_READING},
		'{0,         24'd8000000,  24'd7000000,  1'b0, NO_READING},
		'{0,         24'd8000000,  24'd7800000,  1'b0, NO_READING},
		'{1,         24'd6465444,  24'd8077636,  1'b1, NO_READING},
		'{2,         24'd6465444,  24'd8077636,  1'b1, NO_READING},
		'{3,         24'd6465444,  24'd8077636,  1'b1, NO_READING},
		'{4,         24'hFFFFFF,   24'hFFFFFF,   1'b0, NO_READING},
		'{4,         24'hFFFFFF,   24'd1,        1'b0, NO_READING},
		'{4,         24'd1,        24'd1,        1'b0, NO_READING},
		'{4,         24'h800000,   24'h800000,   1'b0, NO_READING},
		'{5,         24'hFFFFFF,   24'hFFFFFF,   1'b0, NO_READING},
		'{5,         24'd1,        24'd1,        1'b0, NO_READING}
	};

	cal_t      cal_now;
	comp_res_t pending_res[$];
	int        cyc;
	int        n_err;
	int        n_checked;
	int        n_settings;
	int        burst_left;

	function automatic longint sat32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	function automatic comp_res_t compensate(logic [23:0] d1r, logic [23:0] d2r, cal_t c);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, tc, off, sens, t2, off2, sens2, x, y, p;
		comp_res_t r;
		r = NO_READING;
		if (c.pressure_sensitivity == '0 || c.pressure_sensitivity == CAL_BAD_ONES ||
			c.pressure_offset == '0 || c.pressure_offset == CAL_BAD_ONES)
			return r;
		if (d1r == '0 || d2r == '0)
			return r;
		d1 = longint'(d1r);
		d2 = longint'(d2r);
		c1 = longint'(c.pressure_sensitivity);
		c2 = longint'(c.pressure_offset);
		c3 = longint'(c.sens_temp_coeff);
		c4 = longint'(c.offset_temp_coeff);
		c5 = longint'(c.reference_temperature);
		c6 = longint'(c.temp_slope);
		dt = d2 - c5 * 256;
		tc = 2000 + (dt * c6) / 8388608;
		off = c2 * 131072 + ((c4 * dt) >>> 6);
		sens = c1 * 65536 + ((c3 * dt) >>> 7);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		if (tc < 2000) begin
			x = tc - 2000;
			t2 = (dt * dt) >>> 31;
			off2 = 5 * x * x / 2;
			sens2 = 5 * x * x / 4;
			if (tc < -1500) begin
				y = tc + 1500;
				off2 += 7 * y * y;
				sens2 += 11 * y * y / 2;
			end
		end
		tc -= t2;
		off -= off2;
		sens -= sens2;
		p = (((d1 * sens) >>> 21) - off) >>> 15;
		r.valid_res = 1'b1;
		r.temperature_centi = 32'(sat32(tc));
		r.pressure_centi = 32'(sat32(p));
		return r;
	endfunction

	function automatic cal_t pick_cal();
		cal_t c;
		c = cal_t'({$urandom, $urandom, $urandom});
		case ($urandom_range(0, 9))
			6, 7: ;
			8: begin
				c.pressure_sensitivity  = 16'hFFFF >> ($urandom_range(0, 1) * 15);
				c.pressure_offset       = 16'hFFFE >> ($urandom_range(0, 1) * 15);
				c.sens_temp_coeff       = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				c.offset_temp_coeff     = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				c.reference_temperature = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				c.temp_slope            = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			9: begin
				if ($urandom_range(0, 1))
					c.pressure_sensitivity = $urandom_range(0, 1) ? CAL_BAD_ONES : 16'h0000;
				else
					c.pressure_offset = $urandom_range(0, 1) ? CAL_BAD_ONES : 16'h0000;
			end
			default: begin
				c.pressure_sensitivity  = 16'($urandom_range(40000, 50000));
				c.pressure_offset       = 16'($urandom_range(38000, 48000));
				c.sens_temp_coeff       = 16'($urandom_range(20000, 32000));
				c.offset_temp_coeff     = 16'($urandom_range(20000, 32000));
				c.reference_temperature = 16'($urandom_range(28000, 36000));
				c.temp_slope            = 16'($urandom_range(26000, 30000));
			end
		endcase
		return c;
	endfunction

	// temperature raw values mostly spread around the reference point, down into the cold bands
	function automatic logic [23:0] pick_temp_raw(cal_t c);
		longint v;
		int sh;
		case ($urandom_range(0, 39))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'd1;
			3, 4, 5, 6: return 24'($urandom);
			default: begin
				sh = $urandom_range(8, 23);
				v = longint'(c.reference_temperature) * 256 +
					longint'($signed(32'($urandom)) >>> (31 - sh));
				if (v < 1)
					v = 1;
				if (v > 64'sh00FFFFFF)
					v = 64'sh00FFFFFF;
				return v[23:0];
			end
		endcase
	endfunction

	function automatic logic [23:0] pick_press_raw();
		case ($urandom_range(0, 39))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'd1;
			default: return 24'($urandom);
		endcase
	endfunction

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cyc, pending_res.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// result side stall pattern, chosen by bits 10:9 of the cycle count
	always @(negedge clk) begin
		if (arst_n) begin
			case ((cyc >> 9) & 3)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 3) != 0);
				2: res_ch.ready <= ((cyc % 7) < 4);
				default: res_ch.ready <= ((cyc % 23) >= 12);
			endcase
		end
	end

	always @(posedge clk) begin
		comp_res_t exp_r;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_res.size() == 0) begin
				$error("result transfer with nothing expected: valid_res=%0b t=%0d p=%0d",
					res_ch.valid_res, res_ch.temperature_centi, res_ch.pressure_centi);
				n_err++;
			end else begin
				exp_r = pending_res.pop_front();
				n_checked++;
				if (res_ch.valid_res !== exp_r.valid_res) begin
					$error("valid_res: expected %0b, got %0b", exp_r.valid_res, res_ch.valid_res);
					n_err++;
				end
				if (res_ch.temperature_centi !== exp_r.temperature_centi) begin
					$error("temperature_centi: expected %0d, got %0d",
						exp_r.temperature_centi, res_ch.temperature_centi);
					n_err++;
				end
				if (res_ch.pressure_centi !== exp_r.pressure_centi) begin
					$error("pressure_centi: expected %0d, got %0d",
						exp_r.pressure_centi, res_ch.pressure_centi);
					n_err++;
				end
			end
		end
	end

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(logic [REG_IDX_W-1:0] idx, logic [CAL_W-1:0] want);
		logic [DATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got[CAL_W-1:0] !== want) begin
			$error("register %0d readback: expected %0d, got %0d", idx, want, got[CAL_W-1:0]);
			n_err++;
		end
	endtask

	task automatic load_cal(cal_t c);
		apb_write(REG_PSENS,  c.pressure_sensitivity);
		apb_write(REG_POFF,   c.pressure_offset);
		apb_write(REG_TCS,    c.sens_temp_coeff);
		apb_write(REG_TCO,    c.offset_temp_coeff);
		apb_write(REG_TREF,   c.reference_temperature);
		apb_write(REG_TSLOPE, c.temp_slope);
		// writes outside the map must leave every word alone
		if ($urandom_range(0, 1))
			apb_write(REG_UNMAPPED_LO, 16'($urandom));
		else
			apb_write(REG_UNMAPPED_HI, 16'($urandom));
		cal_now = c;
		n_settings++;
		apb_check(REG_PSENS,  cal_now.pressure_sensitivity);
		apb_check(REG_POFF,   cal_now.pressure_offset);
		apb_check(REG_TCS,    cal_now.sens_temp_coeff);
		apb_check(REG_TCO,    cal_now.offset_temp_coeff);
		apb_check(REG_TREF,   cal_now.reference_temperature);
		apb_check(REG_TSLOPE, cal_now.temp_slope);
	endtask

	task automatic new_burst();
		case ($urandom_range(0, 7))
			0: burst_left = $urandom_range(150, 300);
			1, 2: burst_left = 1;
			default: burst_left = $urandom_range(2, 24);
		endcase
	endtask

	task automatic send_conv(logic [23:0] d1, logic [23:0] d2, bit typed, comp_res_t want);
		int gap;
		@(negedge clk);
		conv_ch.valid           <= 1'b1;
		conv_ch.raw_pressure    <= d1;
		conv_ch.raw_temperature <= d2;
		do @(posedge clk); while (!conv_ch.ready);
		pending_res.push_back(typed ? want : compensate(d1, d2, cal_now));
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			conv_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			new_burst();
		end
	endtask

	task automatic drain();
		@(negedge clk);
		conv_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	initial begin
		int cur_cfg;
		cal_t c;
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		conv_ch.valid           = 1'b0;
		conv_ch.raw_pressure    = '0;
		conv_ch.raw_temperature = '0;
		res_ch.ready            = 1'b0;
		cal_now                 = '0;
		cyc                     = 0;
		n_err                   = 0;
		n_checked               = 0;
		n_settings              = 1;
		cur_cfg                 = CFG_RESET;
		new_burst();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].cfg != cur_cfg) begin
				drain();
				cur_cfg = dir_tab[i].cfg;
				load_cal(cfg_tab[cur_cfg]);
			end
			send_conv(dir_tab[i].d1, dir_tab[i].d2, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			c = pick_cal();
			load_cal(c);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_conv(pick_press_raw(), pick_temp_raw(cal_now), 1'b0, NO_READING);
		end

		drain();
		$display("Checked %0d results over %0d calibration settings in %0d cycles",
			n_checked, n_settings, cyc);
		$display("(%0d directed rows, then random pairs under stalls and bursts)", DIR_ROWS);
		if (n_err == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: baro_pressure_temp_compensation.f
hdl/baro_pkg.sv
hdl/baro_if.sv
hdl/baro_cal_regs.sv
hdl/baro_comp_pipe.sv
hdl/baro_pressure_temp_compensation.sv
hdl/baro_chk.sv
tb/tb_baro_pressure_temp_compensation.sv
